// File: src/lodc_pkg.sv
// ----------------------------------------------------------------------------
// lodc_pkg: shared definitions for the lock order deadlock checker
// Status codes, default sizes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lodc_pkg;

  // default sizes
  localparam int LOCK_COUNT_DEF  = 32;
  localparam int STACK_DEPTH_DEF = 16;

  // fixed field widths
  localparam int LOCK_ID_W = 5;
  localparam int STATUS_W  = 3;
  localparam int HELD_W    = 5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MULTI_UNLOCK   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID_UNLOCK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL           = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HALTED         = 3'd5;

  // event kinds
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic                load_in;       // capture the accepted event
    logic                reduce;        // one modulo step on the raw id
    logic                edge_sel_scan; // edge row read follows scan counter
    logic                edge_write;    // record edge top->id
    logic                scan_init;     // seed reach set, clear pass state
    logic                scan_step;     // issue one row of the sweep
    logic                pass_restart;  // start another sweep
    logic                push;
    logic                pop;
    logic                set_halt;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                out_load;      // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic id_ge;       // raw id still at or above the lock count
    logic halted;
    logic level_zero;
    logic level_full;
    logic top_eq_id;
    logic edge_bit;    // edge top->id already recorded
    logic seen_top;    // top reached from id
    logic changed;     // last sweep grew the reach set
    logic cnt_last;    // sweep counter at last row
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: src/lodc_ctrl.sv
// ----------------------------------------------------------------------------
// lodc_ctrl: event sequencer
// Steps one event at a time through id reduction, the stack and edge checks,
// the reachability sweeps and the hand-off of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lodc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lodc_pkg::stat_t stat,
  output lodc_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_DECIDE,
    S_EDGE_CHK,
    S_SCAN,
    S_DRAIN,
    S_EVAL,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (stat.id_ge) begin
          cmd.reduce = 1'b1;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next     = S_RESULT;
        cmd.set_status = 1'b1;
        cmd.status     = lodc_pkg::ST_OK;
        if (stat.halted) begin
          cmd.status = lodc_pkg::ST_HALTED;
        end else if (stat.op == lodc_pkg::OP_RELEASE) begin
          if (stat.level_zero) begin
            cmd.status   = lodc_pkg::ST_MULTI_UNLOCK;
            cmd.set_halt = 1'b1;
          end else if (!stat.top_eq_id) begin
            cmd.status   = lodc_pkg::ST_INVALID_UNLOCK;
            cmd.set_halt = 1'b1;
          end else begin
            cmd.pop = 1'b1;
          end
        end else if (stat.level_full) begin
          cmd.status = lodc_pkg::ST_FULL;
        end else if (stat.level_zero || stat.top_eq_id) begin
          cmd.push = 1'b1;
        end else begin
          // edge row of top is read this cycle
          cmd.set_status = 1'b0;
          state_next     = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        if (stat.edge_bit) begin
          cmd.push       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = lodc_pkg::ST_OK;
          state_next     = S_RESULT;
        end else begin
          cmd.edge_write = 1'b1;
          cmd.scan_init  = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step     = 1'b1;
        cmd.edge_sel_scan = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.seen_top) begin
          cmd.set_status = 1'b1;
          cmd.status     = lodc_pkg::ST_DEADLOCK;
          cmd.set_halt   = 1'b1;
          state_next     = S_RESULT;
        end else if (stat.changed) begin
          cmd.pass_restart = 1'b1;
          state_next       = S_SCAN;
        end else begin
          cmd.push       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = lodc_pkg::ST_OK;
          state_next     = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: src/lodc_dp.sv
// ----------------------------------------------------------------------------
// lodc_dp: datapath of the lock order deadlock checker
// Held stack memory, edge matrix memory with row valid bits, reach-set sweep,
// halt flag and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lodc_dp #(
  parameter int LOCK_COUNT  = lodc_pkg::LOCK_COUNT_DEF,
  parameter int STACK_DEPTH = lodc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_op,
  input  wire logic [lodc_pkg::LOCK_ID_W-1:0] in_lock_id,
  input  wire lodc_pkg::cmd_t                 cmd,
  output lodc_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lodc_pkg::STATUS_W-1:0]       out_status,
  output logic [lodc_pkg::HELD_W-1:0]         out_held
);

  localparam int ID_W  = $clog2(LOCK_COUNT);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RAW_W = lodc_pkg::LOCK_ID_W;

  // event registers
  logic                         op_q;
  logic [RAW_W-1:0]             raw_q;
  logic [ID_W+RAW_W-1:0]        raw_ext;
  logic [ID_W-1:0]              id;
  logic [lodc_pkg::STATUS_W-1:0] status_q;

  // stack
  logic [ID_W-1:0]  stack_mem [STACK_DEPTH];
  logic [ID_W-1:0]  top_q;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_dec;
  logic [SA_W-1:0]  stk_raddr;
  logic [SA_W-1:0]  stk_waddr;
  logic [LVL_W+lodc_pkg::HELD_W-1:0] level_ext;
  logic             halted;

  // edge matrix and sweep
  logic [LOCK_COUNT-1:0] edge_mem [LOCK_COUNT];
  logic [LOCK_COUNT-1:0] row_vld;
  logic [LOCK_COUNT-1:0] rd_row;
  logic [LOCK_COUNT-1:0] id_bit;
  logic [LOCK_COUNT-1:0] seen;
  logic [ID_W-1:0]       edge_raddr;
  logic [ID_W-1:0]       cnt;
  logic [ID_W-1:0]       proc_idx;
  logic                  proc_vld;
  logic                  changed;

  assign raw_ext    = {{ID_W{1'b0}}, raw_q};
  assign id         = raw_ext[ID_W-1:0];
  assign id_bit     = LOCK_COUNT'(1) << id;
  assign level_dec  = level - LVL_W'(1);
  assign stk_raddr  = level_dec[SA_W-1:0];
  assign stk_waddr  = level[SA_W-1:0];
  assign level_ext  = {{lodc_pkg::HELD_W{1'b0}}, level};
  assign edge_raddr = cmd.edge_sel_scan ? cnt : top_q;

  // status to controller
  always_comb begin
    stat.op         = op_q;
    stat.id_ge      = ({2'b00, raw_q} >= 7'(LOCK_COUNT));
    stat.halted     = halted;
    stat.level_zero = (level == '0);
    stat.level_full = (level >= LVL_W'(STACK_DEPTH));
    stat.top_eq_id  = (top_q == id);
    stat.edge_bit   = rd_row[id];
    stat.seen_top   = seen[top_q];
    stat.changed    = changed;
    stat.cnt_last   = (cnt == ID_W'(LOCK_COUNT - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // event capture, modulo reduction, status code
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= in_op;
      raw_q <= in_lock_id;
    end else if (cmd.reduce) begin
      raw_q <= raw_q - RAW_W'(LOCK_COUNT);
    end
    if (cmd.set_status) begin
      status_q <= cmd.status;
    end
  end

  // held stack memory, top read every cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[stk_waddr] <= id;
    end
    top_q <= stack_mem[stk_raddr];
  end

  // stack level and halt
  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      halted <= 1'b0;
    end else begin
      if (cmd.push) begin
        level <= level + LVL_W'(1);
      end else if (cmd.pop) begin
        level <= level_dec;
      end
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
    end
  end

  // edge matrix memory
  always_ff @(posedge clk) begin
    if (cmd.edge_write) begin
      edge_mem[top_q] <= rd_row | id_bit;
    end
  end

  // row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.edge_write) begin
      row_vld[top_q] <= 1'b1;
    end
  end

  // registered row read, invalid rows read as empty
  always_ff @(posedge clk) begin
    rd_row   <= row_vld[edge_raddr] ? edge_mem[edge_raddr] : '0;
    proc_idx <= cnt;
  end

  // sweep counter and reach set
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init || cmd.pass_restart) begin
      cnt     <= '0;
      changed <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt <= cnt + ID_W'(1);
    end
    if (cmd.scan_init) begin
      seen <= id_bit;
    end else if (proc_vld && seen[proc_idx]) begin
      seen <= seen | rd_row;
      if ((rd_row & ~seen) != '0) begin
        changed <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status_q;
      out_held   <= level_ext[lodc_pkg::HELD_W-1:0];
    end
  end

  // checks
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag dropped");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!stat.level_full && !halted))
    else $error("push with full stack or while halted");

  a_pop_match: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (!stat.level_zero && stat.top_eq_id))
    else $error("pop without matching top");

  a_edge_new: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_write |-> (!rd_row[id] && (top_q != id)))
    else $error("edge write of a recorded or self edge");

endmodule

`default_nettype wire

// File: src/lock_order_deadlock_checker.sv
// ----------------------------------------------------------------------------
// lock_order_deadlock_checker: lock order graph cycle detector
// Tracks held locks on a stack, records lock order edges and reports a
// deadlock when a new edge closes a cycle.
//
//  channel  | dir | tdata                           | tuser
//  ---------+-----+---------------------------------+-----------------------
//  s_axis   | in  | [4:0] lock_id, [7:5] zero       | [0] op (1 = release)
//  m_axis   | out | [2:0] status, [7:3] held_count  | -
//
// One event at a time, stepping through idle, reduce, decide and result; an
// acquire that looks up an existing edge also passes the edge check, and a
// raw id at or above LOCK_COUNT stays in reduce for further modulo steps.
// An acquire that adds a new edge then runs sweeps (one row read per cycle,
// then drain and evaluate) until the reach set settles or holds the top.
// Reset clears the stack level, the halt flag and the edge row valid bits at
// once; no clearing pass. A stalled result waits in the output register; the
// next event is taken once the previous result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_deadlock_checker #(
  parameter int LOCK_COUNT  = lodc_pkg::LOCK_COUNT_DEF,
  parameter int STACK_DEPTH = lodc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [4:0] lock_id, [7:5] zero
  input  wire logic       s_axis_tuser,   // [0] op
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [2:0] status, [7:3] held_count
);

  lodc_pkg::cmd_t  cmd;
  lodc_pkg::stat_t stat;

  logic [lodc_pkg::STATUS_W-1:0] out_status;
  logic [lodc_pkg::HELD_W-1:0]   out_held;

  assign m_axis_tdata = {out_held, out_status};

  lodc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lodc_dp #(
    .LOCK_COUNT  (LOCK_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_axis_tuser),
    .in_lock_id (s_axis_tdata[lodc_pkg::LOCK_ID_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_held   (out_held)
  );

endmodule

`default_nettype wire

// File: tb/lodc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lodc_checker: scoreboard for the lock order deadlock checker
// Watches both stream channels. Every event transfer on the input side runs
// through a local model of the held stack, the lock order matrix and the
// halt flag, and the predicted status and held count are queued. Every
// result transfer is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module lodc_checker #(
  parameter int LOCK_COUNT  = lodc_pkg::LOCK_COUNT_DEF,
  parameter int STACK_DEPTH = lodc_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] lock_id, [7:5] zero
  input  logic       s_axis_tuser,   // [0] op
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [2:0] status, [7:3] held_count
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [lodc_pkg::STATUS_W-1:0] status;
    logic [lodc_pkg::HELD_W-1:0]   held;
  } lock_result_t;

  // model state
  logic [LOCK_COUNT-1:0]          order_rows [LOCK_COUNT];  // bit b of row a: a held while b taken
  logic [lodc_pkg::LOCK_ID_W-1:0] held_ids   [STACK_DEPTH];
  int                             held_level;
  logic                           halted;

  lock_result_t results_due [$];
  lock_result_t predicted;
  lock_result_t oldest;

  // transitive closure from src over the recorded order
  function automatic logic lock_reaches(int src, int dst);
    logic [LOCK_COUNT-1:0] seen;
    logic [LOCK_COUNT-1:0] grown;
    seen      = '0;
    seen[src] = 1'b1;
    grown     = seen;
    do begin
      seen = grown;
      for (int n = 0; n < LOCK_COUNT; n++) begin
        if (seen[n]) grown |= order_rows[n];
      end
    end while (grown != seen);
    return seen[dst];
  endfunction

  // one event through the model; returns the result it must produce
  task automatic apply_lock_event(input logic op,
                                  input logic [lodc_pkg::LOCK_ID_W-1:0] raw_id,
                                  output lock_result_t res);
    int   id;
    int   top;
    logic pushing;
    id         = int'(raw_id) % LOCK_COUNT;
    res.status = lodc_pkg::ST_OK;
    if (halted) begin
      res.status = lodc_pkg::ST_HALTED;
    end else if (op == lodc_pkg::OP_ACQUIRE) begin
      if (held_level >= STACK_DEPTH) begin
        res.status = lodc_pkg::ST_FULL;
      end else begin
        pushing = 1'b1;
        if (held_level > 0) begin
          top = held_ids[held_level-1];
          // only a fresh edge can close a cycle
          if (top != id && !order_rows[top][id]) begin
            order_rows[top][id] = 1'b1;
            if (lock_reaches(id, top)) begin
              res.status = lodc_pkg::ST_DEADLOCK;
              halted     = 1'b1;
              pushing    = 1'b0;
            end
          end
        end
        if (pushing) begin
          held_ids[held_level] = lodc_pkg::LOCK_ID_W'(id);
          held_level++;
        end
      end
    end else begin
      if (held_level == 0) begin
        res.status = lodc_pkg::ST_MULTI_UNLOCK;
        halted     = 1'b1;
      end else if (int'(held_ids[held_level-1]) != id) begin
        res.status = lodc_pkg::ST_INVALID_UNLOCK;
        halted     = 1'b1;
      end else begin
        held_level--;
      end
    end
    res.held = lodc_pkg::HELD_W'(held_level);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < LOCK_COUNT; a++) order_rows[a] = '0;
      for (int s = 0; s < STACK_DEPTH; s++) held_ids[s] = '0;
      held_level = 0;
      halted     = 1'b0;
      results_due.delete();
      fail_count = 0;
    end else begin
      // result side first: a result never belongs to an event taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result %h with no event outstanding", m_axis_tdata));
        end else begin
          oldest = results_due.pop_front();
          if (m_axis_tdata[2:0] != oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tdata[2:0], oldest.status));
          if (m_axis_tdata[7:3] != oldest.held)
            report_mismatch($sformatf("held_count %0d, expected %0d",
                                      m_axis_tdata[7:3], oldest.held));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_lock_event(s_axis_tuser, s_axis_tdata[lodc_pkg::LOCK_ID_W-1:0], predicted);
        results_due.push_back(predicted);
      end
    end
    pending = results_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the lock order deadlock checker
// Drives lock events in bursts: a few directed cases, then nested acquire
// and release runs that follow a random global lock ranking so that the
// graph stays acyclic, with stack fill runs and full-stack noise. One fatal
// event of a random kind closes the run, followed by events in halt.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LOCKS          = lodc_pkg::LOCK_COUNT_DEF;
  localparam int DEPTH          = lodc_pkg::STACK_DEPTH_DEF;
  localparam int ID_W           = lodc_pkg::LOCK_ID_W;
  localparam int RANDOM_EVENTS  = 950;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 128;
  localparam int HALT_EVENTS    = 24;

  // receiver stall patterns
  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_SPARSE = 2;

  // fatal event that ends the normal part of the run
  localparam int END_DEADLOCK = 0;
  localparam int END_MULTI    = 1;
  localparam int END_INVALID  = 2;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [4:0] lock_id, [7:5] zero
  logic       s_axis_tuser  = 1'b0; // [0] op
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [2:0] status, [7:3] held_count

  int fail_count;
  int pending;

  // stimulus side view of the held stack; no fatal event before the end
  int gen_ids [DEPTH];
  int gen_level;
  int rank    [LOCKS];
  int by_rank [LOCKS];
  int burst_left;
  int events_sent;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  lock_order_deadlock_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lodc_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // receiver backpressure: runs of free flow, coin flips and sparse ready
  int stall_mode = READY_ALWAYS;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      READY_ALWAYS: begin
        m_axis_tready = 1'b1;
      end
      READY_COIN: begin
        m_axis_tready = 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready = ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  // one event transfer; entered and left at a falling edge
  task automatic send_event(input logic op, input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, id};
    s_axis_tuser  = op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    events_sent++;
  endtask

  task automatic acquire_lock(input int id);
    send_event(lodc_pkg::OP_ACQUIRE, ID_W'(id));
    if (gen_level < DEPTH) begin
      gen_ids[gen_level] = id;
      gen_level++;
    end
  endtask

  task automatic release_top();
    send_event(lodc_pkg::OP_RELEASE, ID_W'(gen_ids[gen_level-1]));
    gen_level--;
  endtask

  task automatic release_all();
    while (gen_level > 0) release_top();
  endtask

  // one step of the nested walk; below full depth, a lock taken is the top again or ranks above it
  task automatic walk_step();
    int top;
    if (gen_level == 0) begin
      acquire_lock(by_rank[$urandom_range(0, LOCKS - 1)]);
    end else if (gen_level == DEPTH) begin
      if ($urandom_range(0, 99) < 40) acquire_lock($urandom_range(0, LOCKS - 1));
      else release_top();
    end else if ($urandom_range(0, 99) < 55) begin
      top = gen_ids[gen_level-1];
      if (rank[top] == LOCKS - 1 || $urandom_range(0, 4) == 0) acquire_lock(top);
      else acquire_lock(by_rank[$urandom_range(rank[top] + 1, LOCKS - 1)]);
    end else begin
      release_top();
    end
  endtask

  // reacquire the top until the stack is full, knock on it, then unwind
  task automatic fill_stack();
    if (gen_level == 0) acquire_lock(by_rank[$urandom_range(0, LOCKS - 1)]);
    while (gen_level < DEPTH) acquire_lock(gen_ids[gen_level-1]);
    repeat ($urandom_range(1, 3)) acquire_lock($urandom_range(0, LOCKS - 1));
    release_all();
  endtask

  // watchdog: too long without any transfer ends the run
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int swap;
    int tmp;
    int r1;
    int r2;
    int end_kind;
    gen_level   = 0;
    burst_left  = 0;
    events_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty stack, reacquire of top, fresh edge with search,
    // edge already present, extreme ids
    acquire_lock(0);
    acquire_lock(0);
    acquire_lock(LOCKS - 1);
    acquire_lock(LOCKS - 1);
    release_all();
    acquire_lock(0);
    acquire_lock(LOCKS - 1);
    release_all();
    acquire_lock(LOCKS - 1);
    release_all();

    // random global ranking; the directed edge 0 -> last must respect it
    for (int i = 0; i < LOCKS; i++) by_rank[i] = i;
    for (int i = LOCKS - 1; i > 0; i--) begin
      swap          = $urandom_range(0, i);
      tmp           = by_rank[i];
      by_rank[i]    = by_rank[swap];
      by_rank[swap] = tmp;
    end
    for (int i = 0; i < LOCKS; i++) rank[by_rank[i]] = i;
    if (rank[0] > rank[LOCKS-1]) begin
      by_rank[rank[0]]       = LOCKS - 1;
      by_rank[rank[LOCKS-1]] = 0;
      tmp                    = rank[0];
      rank[0]                = rank[LOCKS-1];
      rank[LOCKS-1]          = tmp;
    end

    // random nested runs
    events_sent = 0;
    while (events_sent < RANDOM_EVENTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) fill_stack();
      else walk_step();
    end

    // one fatal event, then the block must answer halted
    end_kind = $urandom_range(END_DEADLOCK, END_INVALID);
    case (end_kind)
      END_DEADLOCK: begin
        release_all();
        r1 = $urandom_range(0, LOCKS - 2);
        r2 = $urandom_range(r1 + 1, LOCKS - 1);
        acquire_lock(by_rank[r1]);
        acquire_lock(by_rank[r2]);
        release_all();
        acquire_lock(by_rank[r2]);
        send_event(lodc_pkg::OP_ACQUIRE, ID_W'(by_rank[r1]));
      end
      END_MULTI: begin
        release_all();
        send_event(lodc_pkg::OP_RELEASE, ID_W'($urandom_range(0, LOCKS - 1)));
      end
      default: begin
        if (gen_level == 0) acquire_lock($urandom_range(0, LOCKS - 1));
        send_event(lodc_pkg::OP_RELEASE,
                   ID_W'(gen_ids[gen_level-1] ^ $urandom_range(1, LOCKS - 1)));
      end
    endcase
    repeat (HALT_EVENTS)
      send_event(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, LOCKS - 1)));
    s_axis_tvalid = 1'b0;

    // drain, then watch for stray results
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
